### hw/rtl/assert_macros.svh
// Assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk_s, rst_ns, prop, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) prop) else $error(msg);
`define ASSERT_NEVER(label, clk_s, rst_ns, cond, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_ns) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk_s, rst_ns, prop, msg)
`define ASSERT_NEVER(label, clk_s, rst_ns, cond, msg)
`endif
`endif

### hw/rtl/rsbt_pkg.sv
package rsbt_pkg;

    localparam int ENTRANT_W = 7;
    localparam int ROUND_W   = 8;
    localparam int TIME_W    = 24;
    localparam int RANK_W    = 6;

    typedef struct packed {
        logic [ENTRANT_W-1:0] entrant;
        logic [ROUND_W-1:0]   round_no;
        logic [TIME_W-1:0]    time_ms;
        logic                 final_item;
    } in_t;

    typedef struct packed {
        logic [ENTRANT_W-1:0] out_entrant;
        logic [ROUND_W-1:0]   out_round;
        logic [TIME_W-1:0]    out_time_ms;
        logic [RANK_W-1:0]    rank;
        logic                 end_of_run;
        logic                 overflowed;
    } out_t;

    // stored record, 39 bits
    typedef struct packed {
        logic [ENTRANT_W-1:0] entrant;
        logic [ROUND_W-1:0]   round_no;
        logic [TIME_W-1:0]    time_ms;
    } rec_t;

    typedef struct packed {
        rec_t lower;
        rec_t upper;
    } cmp_res_t;

endpackage

### hw/rtl/rsbt_ram.sv
module rsbt_ram #(
    parameter int WIDTH = 39,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/rsbt_cmp.sv
// compare-exchange: the larger time travels on, strict greater-than keeps ties in order
module rsbt_cmp (
    input  rsbt_pkg::rec_t     held,
    input  rsbt_pkg::rec_t     incoming,
    output rsbt_pkg::cmp_res_t res
);

    logic greater;

    assign greater = held.time_ms > incoming.time_ms;

    always_comb
    begin
        if (greater)
        begin
            res.lower = incoming;
            res.upper = held;
        end
        else
        begin
            res.lower = held;
            res.upper = incoming;
        end
    end

endmodule

### hw/rtl/record_sort_by_time.sv
// Record sorter, ascending by time.
// Input: a beat is taken at a rising edge with start high and busy low.
// Each beat loads one record; a zero time drops it, a full store drops it
// and sets the overflow mark. Loading takes one cycle per beat.
// The beat with final_item set loads its record and then starts the sort.
// Sort: N-1 passes over one RAM with a read and a write port and one
// compare-exchange unit; a pass runs S_PSTART, S_PLOAD, S_PRUN, S_PTAIL;
// busy stays high throughout. An empty set gives no results.
// Output: N results, one per cycle, each shown for one cycle with strobe
// high, rank from 0, end_of_run on the last and overflowed on all. The
// first result is read in S_EMIT after the sort, or after the final beat
// when N = 1, and shown from the RAM read register. The receiver cannot
// stall; results are simply taken.
// busy drops as the last result is shown; a new set may load at once.
// Reset (rst_n low) empties the store and clears the overflow mark; the
// RAM itself needs no clearing.
`include "assert_macros.svh"

module record_sort_by_time #(
    parameter int MAX_RECORDS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  rsbt_pkg::in_t    item,
    output logic             strobe,
    output rsbt_pkg::out_t   result
);

    localparam int AW    = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PSTART = 3'd1;
    localparam logic [2:0] S_PLOAD  = 3'd2;
    localparam logic [2:0] S_PRUN   = 3'd3;
    localparam logic [2:0] S_PTAIL  = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [AW-1:0]    k_reg, k_next;
    logic [AW-1:0]    last_reg, last_next;
    rsbt_pkg::rec_t   hold_reg, hold_next;
    logic             strobe_reg, strobe_next;
    logic [rsbt_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic             eor_reg, eor_next;
    logic             ovfo_reg, ovfo_next;

    logic             we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    rsbt_pkg::rec_t   wdata;
    rsbt_pkg::rec_t   rd_data;
    rsbt_pkg::rec_t   in_rec;
    rsbt_pkg::cmp_res_t cmp_res;

    assign in_rec.entrant  = item.entrant;
    assign in_rec.round_no = item.round_no;
    assign in_rec.time_ms  = item.time_ms;

    rsbt_ram #(
        .WIDTH ($bits(rsbt_pkg::rec_t)),
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    rsbt_cmp u_cmp (
        .held     (hold_reg),
        .incoming (rd_data),
        .res      (cmp_res)
    );

    always_comb
    begin
        logic [CNT_W-1:0] cnt_tmp;
        logic             ovf_tmp;
        cnt_tmp     = count_reg;
        ovf_tmp     = ovf_reg;
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        k_next      = k_reg;
        last_next   = last_reg;
        hold_next   = hold_reg;
        strobe_next = 1'b0;
        rank_next   = rank_reg;
        eor_next    = 1'b0;
        ovfo_next   = ovfo_reg;
        we          = 1'b0;
        waddr       = count_reg[AW-1:0];
        wdata       = in_rec;
        raddr       = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (item.time_ms != '0)
                    begin
                        if (count_reg < CNT_W'(MAX_RECORDS))
                        begin
                            we      = 1'b1;
                            cnt_tmp = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_tmp = 1'b1;
                        end
                    end
                    count_next = cnt_tmp;
                    ovf_next   = ovf_tmp;
                    if (item.final_item)
                    begin
                        if (cnt_tmp == '0)
                        begin
                            ovf_next = 1'b0;
                        end
                        else if (cnt_tmp == CNT_W'(1))
                        begin
                            k_next     = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            last_next  = AW'(cnt_tmp - CNT_W'(1));
                            state_next = S_PSTART;
                        end
                    end
                end
            end
            S_PSTART:
            begin
                raddr      = '0;
                state_next = S_PLOAD;
            end
            S_PLOAD:
            begin
                hold_next  = rd_data;
                raddr      = AW'(1);
                k_next     = AW'(1);
                state_next = S_PRUN;
            end
            S_PRUN:
            begin
                we        = 1'b1;
                waddr     = k_reg - AW'(1);
                wdata     = cmp_res.lower;
                hold_next = cmp_res.upper;
                raddr     = k_reg + AW'(1);
                if (k_reg == last_reg)
                begin
                    state_next = S_PTAIL;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            S_PTAIL:
            begin
                we    = 1'b1;
                waddr = last_reg;
                wdata = hold_reg;
                if (last_reg == AW'(1))
                begin
                    k_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    last_next  = last_reg - AW'(1);
                    state_next = S_PSTART;
                end
            end
            S_EMIT:
            begin
                raddr       = k_reg;
                strobe_next = 1'b1;
                rank_next   = rsbt_pkg::RANK_W'(k_reg);
                ovfo_next   = ovf_reg;
                if (CNT_W'(k_reg) == count_reg - CNT_W'(1))
                begin
                    eor_next   = 1'b1;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            k_reg      <= '0;
            last_reg   <= '0;
            strobe_reg <= 1'b0;
            rank_reg   <= '0;
            eor_reg    <= 1'b0;
            ovfo_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            k_reg      <= k_next;
            last_reg   <= last_next;
            strobe_reg <= strobe_next;
            rank_reg   <= rank_next;
            eor_reg    <= eor_next;
            ovfo_reg   <= ovfo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    assign busy   = state_reg != S_IDLE;
    assign strobe = strobe_reg;

    assign result.out_entrant = rd_data.entrant;
    assign result.out_round   = rd_data.round_no;
    assign result.out_time_ms = rd_data.time_ms;
    assign result.rank        = rank_reg;
    assign result.end_of_run  = eor_reg;
    assign result.overflowed  = ovfo_reg;

    `ASSERT_PROP(a_strobe_after_emit, clk, rst_n, strobe_reg |-> $past(state_reg == S_EMIT), "result beat without emit read")
    `ASSERT_PROP(a_end_back_idle, clk, rst_n, (strobe_reg && eor_reg) |-> (state_reg == S_IDLE), "end of run while still busy")
    `ASSERT_NEVER(a_count_cap, clk, rst_n, count_reg > CNT_W'(MAX_RECORDS), "record count beyond capacity")
    `ASSERT_PROP(a_pass_bounds, clk, rst_n, (state_reg == S_PRUN) |-> (k_reg <= last_reg && k_reg != '0), "pass index out of range")

endmodule

### test/testbench.sv
module testbench;

    localparam int CAPACITY    = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam int SET_QUOTA   = 35;

    // Predicts the ranked burst for each set and holds it until the block shows it.
    class standings_model;
        rsbt_pkg::rec_t held[$];
        bit   dropped;
        rsbt_pkg::out_t due[$];
        int   mismatches;

        function void load_record(rsbt_pkg::in_t beat);
            rsbt_pkg::rec_t r;
            rsbt_pkg::rec_t t;
            rsbt_pkg::out_t o;
            int   n;
            if (beat.time_ms != '0)
            begin
                if (held.size() < CAPACITY)
                begin
                    r.entrant  = beat.entrant;
                    r.round_no = beat.round_no;
                    r.time_ms  = beat.time_ms;
                    held.push_back(r);
                end
                else
                    dropped = 1'b1;
            end
            if (!beat.final_item)
                return;
            n = held.size();
            // strict compare: equal times stay in load order
            for (int p = 0; p + 1 < n; p++)
                for (int k = 0; k + 1 < n - p; k++)
                    if (held[k].time_ms > held[k + 1].time_ms)
                    begin
                        t = held[k];
                        held[k] = held[k + 1];
                        held[k + 1] = t;
                    end
            for (int k = 0; k < n; k++)
            begin
                o.out_entrant = held[k].entrant;
                o.out_round   = held[k].round_no;
                o.out_time_ms = held[k].time_ms;
                o.rank        = k[rsbt_pkg::RANK_W-1:0];
                o.end_of_run  = (k + 1 == n);
                o.overflowed  = dropped;
                due.push_back(o);
            end
            held.delete();
            dropped = 1'b0;
        endfunction

        function void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v)
            begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_standing(rsbt_pkg::out_t got);
            rsbt_pkg::out_t want;
            if (due.size() == 0)
            begin
                $error("result with none due: rank %0d entrant %0d time %0d",
                       got.rank, got.out_entrant, got.out_time_ms);
                mismatches++;
                return;
            end
            want = due.pop_front();
            compare_field("out_entrant", 32'(want.out_entrant), 32'(got.out_entrant));
            compare_field("out_round", 32'(want.out_round), 32'(got.out_round));
            compare_field("out_time_ms", 32'(want.out_time_ms), 32'(got.out_time_ms));
            compare_field("rank", 32'(want.rank), 32'(got.rank));
            compare_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
            compare_field("overflowed", 32'(want.overflowed), 32'(got.overflowed));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    rsbt_pkg::in_t  item;
    logic strobe;
    rsbt_pkg::out_t result;

    standings_model ledger = new;
    int idle_pct;
    int records_sent;
    int quiet = 0;
    int phase_idle[4] = '{0, 60, 0, 21};

    record_sort_by_time #(
        .MAX_RECORDS(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .strobe(strobe),
        .result(result)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            ledger.load_record(item);
        if (rst_n && strobe)
            ledger.check_standing(result);
        if (rst_n && ((start && !busy) || strobe))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic offer(rsbt_pkg::in_t beat);
        logic [$bits(rsbt_pkg::in_t)-1:0] noise;
        logic [63:0] wide;
        int gap;
        start <= 1'b1;
        item  <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 6);
            wide = {$urandom, $urandom};
            noise = wide[$bits(rsbt_pkg::in_t)-1:0];
            start <= 1'b0;
            item  <= noise;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic send_record(int ent, int rnd, int tms, bit fin);
        rsbt_pkg::in_t b;
        b.entrant    = ent[rsbt_pkg::ENTRANT_W-1:0];
        b.round_no   = rnd[rsbt_pkg::ROUND_W-1:0];
        b.time_ms    = tms[rsbt_pkg::TIME_W-1:0];
        b.final_item = fin;
        if (b.time_ms != '0)
            records_sent++;
        offer(b);
    endtask

    task automatic random_set(int n);
        int tms;
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                tms = 0;
            else if (pick < 35)
                tms = $urandom_range(1, 16);                 // many ties
            else if (pick < 45)
                tms = $urandom_range(24'hFF_FF00, 24'hFF_FFFF);
            else
                tms = $urandom_range(1, 24'hFF_FFFF);
            send_record($urandom_range(127), $urandom_range(255), tms, i == n - 1);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        start <= 1'b0;
        item  <= '0;
        idle_pct = 0;
        records_sent = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set: final beat with zero time
        send_record(3, 7, 0, 1'b1);
        // single record, all-ones fields
        send_record(127, 255, 24'hFF_FFFF, 1'b1);
        // zero-time drop, equal times keep order, zero-time final still sorts
        send_record(0, 0, 1, 1'b0);
        send_record(5, 9, 0, 1'b0);
        send_record(20, 1, 24'hFF_FFFF, 1'b0);
        send_record(10, 2, 500, 1'b0);
        send_record(11, 3, 500, 1'b0);
        send_record(12, 4, 0, 1'b1);
        // reverse order
        for (int i = 0; i < 6; i++)
            send_record(40 + i, i, 600 - 100 * i, i == 5);
        // alternating bit patterns
        send_record(7'h55, 8'hAA, 24'hAA_AAAA, 1'b0);
        send_record(7'h2A, 8'h55, 24'h55_5555, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            // each phase sets the chance of idle gaps between input beats; results are never held off
            idle_pct = phase_idle[ph];
            records_sent = 0;
            if (ph == 1)
                random_set(80);                             // overruns the store
            while (records_sent < SET_QUOTA)
            begin
                if ($urandom_range(99) < 6)
                    send_record($urandom_range(127), $urandom_range(255), 0, 1'b1);
                else
                    random_set($urandom_range(1, 12));
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (ledger.due.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (ledger.mismatches == 0 && ledger.due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule
